@@ rtl/ptach_pkg.sv @@
// ----------------------------------------------------------------------------
// ptach_pkg
// Types and constants shared by the pulse tachometer front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package ptach_pkg;

    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int RPM_W       = 6;
    localparam int SPEED_W     = 34;
    localparam int PROD_W      = RPM_W + COUNT_W;
    localparam int SCALE_W     = SPEED_W - PROD_W;
    localparam int STEP_W      = $clog2(SPEED_W);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCALE_W-1:0] SCALE_US  = SCALE_W'(1000000);
    localparam logic [RPM_W-1:0]   RPM_RESET = RPM_W'(30);

    localparam logic ACT_EDGE   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic              action;
        logic              channel;
        logic [TIME_W-1:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic               channel_res;
        logic [SPEED_W-1:0] speed;
    } out_item_t;

    // snapshot of one channel taken by a report
    typedef struct packed {
        logic               channel;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  period;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/pulse_tachometer_rpm_core.sv @@
// result path: a report item goes through the queue pop, two multiply steps,
//   34 divider steps and the output load, which waits while the output is held
// throughput: edge items every cycle unless the queue is full; the bit-serial
//   divider takes a new report only once it is through with the last one; a
//   two-entry queue holds reports waiting for it
// reset: rst_n clears channel counts, periods and marks, sets rpm_per_hz to 30
// ----------------------------------------------------------------------------
// pulse_tachometer_rpm_core
// Two-channel pulse-count tachometer with integer speed reports.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_tachometer_rpm_core #(
    parameter int CHANNELS = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire ptach_pkg::in_item_t         req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output ptach_pkg::out_item_t             rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ptach_pkg::RPM_W-1:0] cfg_wdata
);

    logic [ptach_pkg::RPM_W-1:0] rpm_reg;
    logic                        push;
    ptach_pkg::job_t             push_job;
    logic                        pop;
    ptach_pkg::job_t             pop_job;
    ptach_pkg::q_stat_t          q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg <= ptach_pkg::RPM_RESET;
        end
        else if (cfg_we)
        begin
            rpm_reg <= cfg_wdata;
        end
    end

    ptach_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_job  (push_job),
        .q_stat    (q_stat)
    );

    ptach_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    ptach_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rpm_per_hz (rpm_reg),
        .q_stat     (q_stat),
        .pop_job    (pop_job),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/ptach_front.sv @@
// ----------------------------------------------------------------------------
// ptach_front
// Accepts items, keeps per-channel pulse count, period sum and mark, and
// queues a snapshot for every accepted report.
// ----------------------------------------------------------------------------
`default_nettype none

module ptach_front #(
    parameter int CHANNELS = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire ptach_pkg::in_item_t req,
    output logic                     push,
    output ptach_pkg::job_t          push_job,
    input  wire ptach_pkg::q_stat_t  q_stat
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [ptach_pkg::COUNT_W-1:0] count_reg [CHANNELS];
    logic [ptach_pkg::TIME_W-1:0]  period_reg [CHANNELS];
    logic [ptach_pkg::TIME_W-1:0]  mark_reg [CHANNELS];

    logic [IDX_W-1:0]              idx;
    logic                          ch_ok;
    logic                          acc;
    logic [ptach_pkg::COUNT_W-1:0] count_cur;
    logic [ptach_pkg::TIME_W-1:0]  period_cur;
    logic [ptach_pkg::TIME_W-1:0]  delta;

    assign req_stall  = q_stat.full;
    assign idx        = IDX_W'(req.channel);
    assign ch_ok      = (32'(req.channel) < 32'(CHANNELS));
    assign acc        = req_valid && !req_stall && ch_ok;
    assign count_cur  = count_reg[idx];
    assign period_cur = period_reg[idx];
    // elapsed time wraps with the timestamp
    assign delta      = req.time_us - mark_reg[idx];

    assign push             = acc && (req.action == ptach_pkg::ACT_REPORT);
    assign push_job.channel = req.channel;
    assign push_job.count   = count_cur;
    assign push_job.period  = period_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i]  <= '0;
                period_reg[i] <= '0;
                mark_reg[i]   <= '0;
            end
        end
        else if (acc)
        begin
            if (req.action == ptach_pkg::ACT_EDGE)
            begin
                count_reg[idx]  <= count_cur + ptach_pkg::COUNT_W'(1);
                period_reg[idx] <= period_cur + delta;
            end
            else
            begin
                count_reg[idx]  <= '0;
                period_reg[idx] <= '0;
            end
            mark_reg[idx] <= req.time_us;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ptach_queue.sv @@
// ----------------------------------------------------------------------------
// ptach_queue
// Short queue of report snapshots between the front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ptach_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ptach_pkg::job_t    push_job,
    input  wire logic               pop,
    output ptach_pkg::job_t         pop_job,
    output ptach_pkg::q_stat_t      q_stat
);

    localparam int PTR_W = (ptach_pkg::QUEUE_DEPTH > 1) ? $clog2(ptach_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptach_pkg::QUEUE_DEPTH + 1);

    ptach_pkg::job_t  entry_reg [ptach_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (fill_reg == CNT_W'(ptach_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ptach_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ptach_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ptach_back.sv @@
// ----------------------------------------------------------------------------
// ptach_back
// Scales the pulse count in two multiply steps, divides by the period one
// quotient bit per cycle and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptach_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ptach_pkg::RPM_W-1:0]   rpm_per_hz,
    input  wire ptach_pkg::q_stat_t            q_stat,
    input  wire ptach_pkg::job_t               pop_job,
    output logic                               pop,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output ptach_pkg::out_item_t               rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_DONE
    } state_t;

    state_t                                 state_reg;
    ptach_pkg::job_t                        job_reg;
    logic [ptach_pkg::PROD_W-1:0]           prod_reg;
    logic [ptach_pkg::SPEED_W-1:0]          quo_reg;
    logic [ptach_pkg::TIME_W-1:0]           rem_reg;
    logic [ptach_pkg::STEP_W-1:0]           step_reg;
    logic                                   rsp_valid_reg;
    ptach_pkg::out_item_t                   rsp_reg;

    logic [ptach_pkg::SPEED_W-1:0]          num_next;
    logic [ptach_pkg::TIME_W:0]             rem_sh;
    logic [ptach_pkg::TIME_W:0]             rem_diff;
    logic                                   fits;
    logic [ptach_pkg::TIME_W-1:0]           rem_next;
    logic                                   rsp_take;
    logic                                   out_free;
    logic                                   rsp_load;

    assign num_next = {{ptach_pkg::SCALE_W{1'b0}}, prod_reg}
                    * {{ptach_pkg::PROD_W{1'b0}}, ptach_pkg::SCALE_US};

    // restoring division: dividend shifts out of the top of quo_reg
    assign rem_sh   = {rem_reg, quo_reg[ptach_pkg::SPEED_W-1]};
    assign rem_diff = rem_sh - {1'b0, job_reg.period};
    assign fits     = (rem_sh >= {1'b0, job_reg.period});
    assign rem_next = fits ? rem_diff[ptach_pkg::TIME_W-1:0] : rem_sh[ptach_pkg::TIME_W-1:0];

    assign pop       = (state_reg == S_IDLE) && !q_stat.empty;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;
    assign out_free  = !rsp_valid_reg || rsp_take;
    assign rsp_load  = (state_reg == S_DONE) && out_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            prod_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        job_reg   <= pop_job;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    prod_reg  <= ptach_pkg::PROD_W'(rpm_per_hz)
                               * ptach_pkg::PROD_W'(job_reg.count);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    quo_reg   <= num_next;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    quo_reg  <= {quo_reg[ptach_pkg::SPEED_W-2:0], fits};
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + ptach_pkg::STEP_W'(1);
                    if (step_reg == ptach_pkg::STEP_W'(ptach_pkg::SPEED_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg.channel_res <= job_reg.channel;
                        // no time elapsed in the window reports zero speed
                        rsp_reg.speed       <= (job_reg.period == '0) ? '0 : quo_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/ptach_checker.sv @@
// ----------------------------------------------------------------------------
// ptach_checker
// Port-level checks on the tachometer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptach_checker #(
    parameter int CHANNELS = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic                        req_stall,
    input  wire ptach_pkg::in_item_t         req,
    input  wire logic                        rsp_valid,
    input  wire logic                        rsp_stall,
    input  wire ptach_pkg::out_item_t        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ptach_pkg::RPM_W-1:0] cfg_wdata
);

    logic report_acc;

    assign report_acc = req_valid && !req_stall && (req.action == ptach_pkg::ACT_REPORT)
                        && (32'(req.channel) < 32'(CHANNELS));

    // a stalled result item holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // reset leaves no result pending and no stall
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid && !req_stall)
        else $error("result or stall active in reset");

    // the queue only fills on a report item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(report_acc))
        else $error("stall rose without a queued report");

    // a speed never exceeds the scaled pulse count bound
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.speed <= 34'd16065000000)
            && (32'(rsp.channel_res) < 32'(CHANNELS)))
        else $error("result out of range");

    // a register write carries known data
    a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !$isunknown(cfg_wdata))
        else $error("register write with unknown data");

endmodule

bind pulse_tachometer_rpm_core ptach_checker #(
    .CHANNELS (CHANNELS)
) u_ptach_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
);

`default_nettype wire

@@ verif/ptach_speed_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptach_speed_checker
// Watches the item and result channels of the pulse tachometer, keeps its own
// per-channel count, period and mark, predicts each speed report and compares
// it with what the block hands out.
// ----------------------------------------------------------------------------

module ptach_speed_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic                        req_stall,
    input  wire ptach_pkg::in_item_t         req,
    input  wire logic                        rsp_valid,
    input  wire logic                        rsp_stall,
    input  wire ptach_pkg::out_item_t        rsp,
    input  wire logic                        cfg_we,
    input  wire logic [ptach_pkg::RPM_W-1:0] cfg_wdata,
    output int                               errors,
    output int                               pending
);

    logic [ptach_pkg::RPM_W-1:0]   rpm_per_hz;
    logic [ptach_pkg::COUNT_W-1:0] pulse_cnt  [2];
    logic [ptach_pkg::TIME_W-1:0]  period_acc [2];
    logic [ptach_pkg::TIME_W-1:0]  mark_us    [2];
    ptach_pkg::out_item_t          speed_q    [$];
    int                            err_cnt;

    // exact integer form of pulses per second times the multiplier
    function automatic logic [ptach_pkg::SPEED_W-1:0] tach_speed(
        input logic [ptach_pkg::RPM_W-1:0]   rpm,
        input logic [ptach_pkg::COUNT_W-1:0] cnt,
        input logic [ptach_pkg::TIME_W-1:0]  per);
        longint unsigned num;
        if (per == '0)
            return '0;
        num = 64'd1000000 * 64'(rpm) * 64'(cnt);
        return ptach_pkg::SPEED_W'(num / 64'(per));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        ptach_pkg::out_item_t want;
        ptach_pkg::out_item_t got;
        logic                 ch;
        if (!rst_n)
        begin
            rpm_per_hz = ptach_pkg::RPM_RESET;
            for (int i = 0; i < 2; i++)
            begin
                pulse_cnt[i]  = '0;
                period_acc[i] = '0;
                mark_us[i]    = '0;
            end
            speed_q.delete();
            err_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                rpm_per_hz = cfg_wdata;

            if (req_valid && !req_stall)
            begin
                ch = req.channel;
                if (req.action == ptach_pkg::ACT_EDGE)
                begin
                    pulse_cnt[ch]  = pulse_cnt[ch] + ptach_pkg::COUNT_W'(1);
                    period_acc[ch] = period_acc[ch] + (req.time_us - mark_us[ch]);
                    mark_us[ch]    = req.time_us;
                end
                else
                begin
                    want.channel_res = ch;
                    want.speed       = tach_speed(rpm_per_hz, pulse_cnt[ch], period_acc[ch]);
                    speed_q.push_back(want);
                    pulse_cnt[ch]  = '0;
                    period_acc[ch] = '0;
                    mark_us[ch]    = req.time_us;
                end
            end

            if (rsp_valid && !rsp_stall)
            begin
                got = rsp;
                if (speed_q.size() == 0)
                begin
                    $display("%0t: unexpected report ch %0d speed %0d", $time,
                             got.channel_res, got.speed);
                    err_cnt++;
                end
                else
                begin
                    want = speed_q.pop_front();
                    if (got.channel_res !== want.channel_res)
                    begin
                        $display("%0t: channel mismatch expected %0d actual %0d", $time,
                                 want.channel_res, got.channel_res);
                        err_cnt++;
                    end
                    if (got.speed !== want.speed)
                    begin
                        $display("%0t: speed mismatch expected %0d actual %0d", $time,
                                 want.speed, got.speed);
                        err_cnt++;
                    end
                end
            end

            errors  <= err_cnt;
            pending <= speed_q.size();
        end
    end

endmodule

@@ verif/tb_pulse_tachometer_rpm_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pulse_tachometer_rpm_core
// Drives edge and report items into the tachometer core in random bursts,
// stalls the result side on its own pattern and steps the multiplier through
// several settings; the checker predicts and compares every speed report.
// ----------------------------------------------------------------------------

module tb_pulse_tachometer_rpm_core;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_PAD   = 60;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    ptach_pkg::in_item_t           req       = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    ptach_pkg::out_item_t          rsp;
    logic                          cfg_we    = 1'b0;
    logic [ptach_pkg::RPM_W-1:0]   cfg_wdata = '0;

    int                            errors;
    int                            pending;
    int                            cycle_cnt = 0;
    int                            burst_left = 0;
    logic [ptach_pkg::TIME_W-1:0]  now_us = '0;

    pulse_tachometer_rpm_core #(
        .CHANNELS(2)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    ptach_speed_checker chk (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .errors(errors),
        .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("[pulse_tachometer_rpm_core] ERROR");
            $finish;
        end
    end

    // result side: stretches of no stall, light, heavy and solid stall
    initial
    begin : stall_gen
        int mode;
        int len;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(5, 60);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= 1'b1;
                endcase
            end
        end
    end

    function automatic ptach_pkg::in_item_t mk(input logic act, input logic ch,
                                               input logic [ptach_pkg::TIME_W-1:0] t);
        ptach_pkg::in_item_t it;
        it.action  = act;
        it.channel = ch;
        it.time_us = t;
        return it;
    endfunction

    // called at a clock edge; returns at the edge that takes the item, or after the idle gap that may follow it
    task automatic push_req(input ptach_pkg::in_item_t it);
        int gap;
        req       <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // mostly time-ordered edges and reports, some items with any content
    function automatic ptach_pkg::in_item_t rand_item();
        int k;
        if ($urandom_range(0, 99) < 8)
            return mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      ptach_pkg::TIME_W'($urandom));
        k = $urandom_range(0, 9);
        if (k < 3)
            now_us += ptach_pkg::TIME_W'($urandom_range(0, 3));
        else if (k < 8)
            now_us += ptach_pkg::TIME_W'($urandom_range(1, 20000));
        else
            now_us += ptach_pkg::TIME_W'($urandom);
        return mk(($urandom_range(0, 99) < 20) ? ptach_pkg::ACT_REPORT : ptach_pkg::ACT_EDGE,
                  1'($urandom_range(0, 1)), now_us);
    endfunction

    // one channel: open a window, many edges, then report
    task automatic long_window(input logic ch, input int n_edges, input int step_max);
        push_req(mk(ptach_pkg::ACT_REPORT, ch, now_us));
        now_us += ptach_pkg::TIME_W'(1);
        for (int i = 0; i < n_edges; i++)
        begin
            push_req(mk(ptach_pkg::ACT_EDGE, ch, now_us));
            now_us += ptach_pkg::TIME_W'($urandom_range(0, step_max));
        end
        push_req(mk(ptach_pkg::ACT_REPORT, ch, now_us));
    endtask

    // edges give no result, so pad past the last report's latency too
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_rpm(input logic [ptach_pkg::RPM_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [ptach_pkg::RPM_W-1:0] rpm_plan [9];
        int                          n;

        rpm_plan[0] = 6'd63;
        rpm_plan[1] = 6'd0;
        rpm_plan[2] = 6'd1;
        rpm_plan[3] = 6'd60;
        rpm_plan[4] = ptach_pkg::RPM_W'($urandom_range(1, 60));
        rpm_plan[5] = 6'd61;
        rpm_plan[6] = 6'd62;
        rpm_plan[7] = ptach_pkg::RPM_W'($urandom_range(0, 63));
        rpm_plan[8] = 6'd30;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset multiplier
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b0, 32'd0));           // nothing counted yet
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b0, 32'd1000));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b0, 32'd2000));
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b0, 32'd2500));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b0, 32'd2500));        // pulse with no elapsed time
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b0, 32'd2500));
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b1, 32'hFFFF_FF00));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b1, 32'h0000_0100));   // timestamp wrap
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b1, 32'hFFFF_FFFF));   // period sum wraps
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b1, 32'hFFFF_FFFF));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b0, 32'h8000_0000));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b1, 32'h7FFF_FFFF));
        push_req(mk(ptach_pkg::ACT_EDGE,   1'b0, 32'h0000_0001));
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b0, 32'hAAAA_AAAA));
        push_req(mk(ptach_pkg::ACT_REPORT, 1'b1, 32'h5555_5555));
        now_us = 32'h5555_5555;

        foreach (rpm_plan[p])
        begin
            wait_idle();
            write_rpm(rpm_plan[p]);
            if (rpm_plan[p] == 6'd63)
                long_window(1'b0, 255, 0);               // largest possible speed
            if (rpm_plan[p] == 6'd1)
                long_window(1'b1, 258, 40);              // pulse count wraps
            n = $urandom_range(30, 50);
            repeat (n) push_req(rand_item());
        end

        wait_idle();
        if (errors == 0)
            $display("[pulse_tachometer_rpm_core] OK");
        else
            $display("[pulse_tachometer_rpm_core] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ptach_pkg.sv
rtl/ptach_front.sv
rtl/ptach_queue.sv
rtl/ptach_back.sv
rtl/pulse_tachometer_rpm_core.sv
rtl/ptach_checker.sv
verif/ptach_speed_checker.sv
verif/tb_pulse_tachometer_rpm_core.sv
